>>> hw/rtl/gpf_pkg.sv
// ----------------------------------------------------------------------------
// gpf_pkg
// Shared widths, register codes and stage records for the gravity pair core.
// ----------------------------------------------------------------------------
package gpf_pkg;

    localparam int DSQ_W  = 66;   // squared distance
    localparam int ROOT_W = 33;   // integer square root of it
    localparam int SREM_W = 35;   // square root partial remainder
    localparam int NUM_W  = 129;  // G*mA*mB*|s|
    localparam int DEN_W  = 100;  // D*d
    localparam int Q_W    = 48;   // quotient bits kept
    localparam int F_W    = 48;   // force field width

    localparam logic [F_W-1:0] FMAX     = 48'h7FFF_FFFF_FFFF;
    localparam logic [F_W-1:0] FMIN_MAG = 48'h8000_0000_0000;

    localparam logic [0:0] REG_GRAVITY  = 1'b0;
    localparam logic [0:0] REG_MIN_DIST = 1'b1;

    // one square root stage
    typedef struct packed {
        logic              valid;
        logic              applied;
        logic              sgn_x;
        logic              sgn_y;
        logic [NUM_W-1:0]  num_x;
        logic [NUM_W-1:0]  num_y;
        logic [DSQ_W-1:0]  dsq;
        logic [DSQ_W-1:0]  rad;
        logic [SREM_W-1:0] rem;
        logic [ROOT_W-1:0] root;
    } t_sq;

    // one divider stage, both components
    typedef struct packed {
        logic             valid;
        logic             applied;
        logic             sgn_x;
        logic             sgn_y;
        logic             big_x;
        logic             big_y;
        logic [DEN_W-1:0] den;
        logic [DEN_W-1:0] rem_x;
        logic [DEN_W-1:0] rem_y;
        logic [Q_W-1:0]   lo_x;
        logic [Q_W-1:0]   lo_y;
        logic [Q_W-1:0]   q_x;
        logic [Q_W-1:0]   q_y;
    } t_dv;

    // one result item
    typedef struct packed {
        logic signed [F_W-1:0] fax;
        logic signed [F_W-1:0] fay;
        logic signed [F_W-1:0] fbx;
        logic signed [F_W-1:0] fby;
        logic                  applied;
        logic                  saturated;
    } t_res;

endpackage

>>> hw/rtl/gpf_sqrt_step.sv
// ----------------------------------------------------------------------------
// gpf_sqrt_step
// One registered digit of the integer square root: two radicand bits in,
// one root bit out.
// ----------------------------------------------------------------------------
module gpf_sqrt_step (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  gpf_pkg::t_sq i_stg,
    output gpf_pkg::t_sq o_stg
);
    import gpf_pkg::*;

    t_sq               n_stg;
    t_sq               r_stg;
    logic [SREM_W+1:0] w_acc;
    logic [SREM_W+1:0] w_trial;

    always_comb begin
        n_stg   = i_stg;
        w_acc   = {i_stg.rem, i_stg.rad[DSQ_W-1 -: 2]};
        w_trial = {2'b00, i_stg.root, 2'b01};
        n_stg.rad = i_stg.rad << 2;
        if (w_acc >= w_trial) begin
            n_stg.rem  = SREM_W'(w_acc - w_trial);
            n_stg.root = {i_stg.root[ROOT_W-2:0], 1'b1};
        end else begin
            n_stg.rem  = w_acc[SREM_W-1:0];
            n_stg.root = {i_stg.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg.valid <= 1'b0;
        end else if (i_en) begin
            r_stg <= n_stg;
        end
    end

    assign o_stg = r_stg;

endmodule

>>> hw/rtl/gpf_div_step.sv
// ----------------------------------------------------------------------------
// gpf_div_step
// One registered restoring division step for the x and y force quotients.
// ----------------------------------------------------------------------------
module gpf_div_step (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  gpf_pkg::t_dv i_stg,
    output gpf_pkg::t_dv o_stg
);
    import gpf_pkg::*;

    t_dv            n_stg;
    t_dv            r_stg;
    logic [DEN_W:0] w_tx;
    logic [DEN_W:0] w_ty;
    logic [DEN_W:0] w_den;

    always_comb begin
        n_stg = i_stg;
        w_den = {1'b0, i_stg.den};
        w_tx  = {i_stg.rem_x, i_stg.lo_x[Q_W-1]};
        w_ty  = {i_stg.rem_y, i_stg.lo_y[Q_W-1]};
        n_stg.lo_x = i_stg.lo_x << 1;
        n_stg.lo_y = i_stg.lo_y << 1;
        if (w_tx >= w_den) begin
            n_stg.rem_x = DEN_W'(w_tx - w_den);
            n_stg.q_x   = {i_stg.q_x[Q_W-2:0], 1'b1};
        end else begin
            n_stg.rem_x = w_tx[DEN_W-1:0];
            n_stg.q_x   = {i_stg.q_x[Q_W-2:0], 1'b0};
        end
        if (w_ty >= w_den) begin
            n_stg.rem_y = DEN_W'(w_ty - w_den);
            n_stg.q_y   = {i_stg.q_y[Q_W-2:0], 1'b1};
        end else begin
            n_stg.rem_y = w_ty[DEN_W-1:0];
            n_stg.q_y   = {i_stg.q_y[Q_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg.valid <= 1'b0;
        end else if (i_en) begin
            r_stg <= n_stg;
        end
    end

    assign o_stg = r_stg;

endmodule

>>> hw/rtl/gpf_out_buf.sv
// ----------------------------------------------------------------------------
// gpf_out_buf
// Two-entry result queue; its full flag holds the pipeline.
// ----------------------------------------------------------------------------
module gpf_out_buf (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gpf_pkg::t_res i_data,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_ready,
    output gpf_pkg::t_res o_data
);
    import gpf_pkg::*;

    t_res       r_slot [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic       w_pop;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign w_pop   = o_valid & i_ready;
    assign o_data  = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + 2'(i_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

endmodule

>>> hw/rtl/gravity_pair_force_core.sv
// ----------------------------------------------------------------------------
// gravity_pair_force_core
// Newtonian pair force in 2D: separation, exact squared distance, pipelined
// square root and division, saturation to signed Q32.16.
// ----------------------------------------------------------------------------
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+------------------------------
//  in      | in  | i_in_valid / o_in_ready   | positions A,B, masses A,B
//  out     | out | o_out_valid / i_out_ready | forces A,B, applied, saturated
//  cfg     | in  | i_cfg_we (no wait)        | i_cfg_index, i_cfg_data
//
//  One item per cycle while the result queue has room; from accept to result: 5
//  front stages, 33 root digits, 3 denominator stages, 48 quotient bits, 1 queue.
//  The 48-step divider chain dominates the latency.
//  Reset (synchronous, active low) clears valid bits and the queue; config
//  returns to G = 1.0, min distance = 5.0.
//  The whole pipeline advances together while the 2-entry result queue has
//  room, so a stalled output still takes in items until the queue fills.
// ----------------------------------------------------------------------------
module gravity_pair_force_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [0:0]                     i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    // input items
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [31:0]             i_pos_a_x,
    input  logic signed [31:0]             i_pos_a_y,
    input  logic signed [31:0]             i_pos_b_x,
    input  logic signed [31:0]             i_pos_b_y,
    input  logic [31:0]                    i_mass_a,
    input  logic [31:0]                    i_mass_b,
    // result items
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [gpf_pkg::F_W-1:0] o_force_a_x,
    output logic signed [gpf_pkg::F_W-1:0] o_force_a_y,
    output logic signed [gpf_pkg::F_W-1:0] o_force_b_x,
    output logic signed [gpf_pkg::F_W-1:0] o_force_b_y,
    output logic                           o_applied,
    output logic                           o_saturated
);
    import gpf_pkg::*;

    localparam logic [31:0] GRAVITY_RESET  = 32'd65536;
    localparam logic [31:0] MIN_DIST_RESET = 32'd327680;

    // {sat, value}
    function automatic logic [F_W:0] clamp_pos(input logic [Q_W-1:0] q, input logic big);
        logic [F_W:0] res;
        if (big || (q > FMAX)) begin
            res = {1'b1, FMAX};
        end else begin
            res = {1'b0, q};
        end
        return res;
    endfunction

    // {sat, value}; -2^47 is the widest negative
    function automatic logic [F_W:0] clamp_neg(input logic [Q_W-1:0] q, input logic big);
        logic [F_W:0] res;
        if (big || (q > FMIN_MAG)) begin
            res = {1'b1, FMIN_MAG};
        end else begin
            res = {1'b0, F_W'(0) - q};
        end
        return res;
    endfunction

    // ---------------- control ----------------
    logic w_en;
    logic w_full;
    logic w_take;

    assign w_en       = ~w_full;
    assign o_in_ready = w_en;
    assign w_take     = i_in_valid & w_en;

    // ---------------- config registers ----------------
    logic [31:0] r_gravity;
    logic [31:0] r_min_dist;
    logic [63:0] r_min_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity  <= GRAVITY_RESET;
            r_min_dist <= MIN_DIST_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_GRAVITY:  r_gravity  <= i_cfg_data;
                REG_MIN_DIST: r_min_dist <= i_cfg_data;
                default:      r_gravity  <= r_gravity;
            endcase
        end
    end

    // threshold squared, refreshed every cycle
    always_ff @(posedge i_clk) begin
        r_min_sq <= 64'(r_min_dist) * 64'(r_min_dist);
    end

    // ---------------- P1: separation, G*mA ----------------
    logic        r1_valid;
    logic [32:0] r1_sx, r1_sy;
    logic [31:0] r1_mb;
    logic [63:0] r1_gm1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= w_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_sx  <= {i_pos_b_x[31], i_pos_b_x} - {i_pos_a_x[31], i_pos_a_x};
            r1_sy  <= {i_pos_b_y[31], i_pos_b_y} - {i_pos_a_y[31], i_pos_a_y};
            r1_mb  <= i_mass_b;
            r1_gm1 <= 64'(r_gravity) * 64'(i_mass_a);
        end
    end

    // ---------------- P2: magnitudes, gm partials ----------------
    logic        r2_valid;
    logic [32:0] r2_ax, r2_ay;
    logic        r2_sgn_x, r2_sgn_y;
    logic [63:0] r2_gmlo, r2_gmhi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_ax    <= r1_sx[32] ? (33'd0 - r1_sx) : r1_sx;
            r2_ay    <= r1_sy[32] ? (33'd0 - r1_sy) : r1_sy;
            r2_sgn_x <= r1_sx[32];
            r2_sgn_y <= r1_sy[32];
            r2_gmlo  <= 64'(r1_gm1[31:0]) * 64'(r1_mb);
            r2_gmhi  <= 64'(r1_gm1[63:32]) * 64'(r1_mb);
        end
    end

    // ---------------- P3: squares, gm ----------------
    logic        r3_valid;
    logic [65:0] r3_sqx, r3_sqy;
    logic [95:0] r3_gm;
    logic [32:0] r3_ax, r3_ay;
    logic        r3_sgn_x, r3_sgn_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_sqx   <= 66'(r2_ax) * 66'(r2_ax);
            r3_sqy   <= 66'(r2_ay) * 66'(r2_ay);
            r3_gm    <= 96'(r2_gmlo) + (96'(r2_gmhi) << 32);
            r3_ax    <= r2_ax;
            r3_ay    <= r2_ay;
            r3_sgn_x <= r2_sgn_x;
            r3_sgn_y <= r2_sgn_y;
        end
    end

    // ---------------- P4: D, distance test, numerator partials ----------------
    logic             r4_valid;
    logic [DSQ_W-1:0] r4_dsq;
    logic             r4_applied;
    logic             r4_sgn_x, r4_sgn_y;
    logic [64:0]      r4_px0, r4_px1, r4_px2;
    logic [64:0]      r4_py0, r4_py1, r4_py2;
    logic [DSQ_W-1:0] w_dsq;

    assign w_dsq = r3_sqx + r3_sqy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (w_en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_dsq     <= w_dsq;
            r4_applied <= (w_dsq > DSQ_W'(r_min_sq));
            r4_sgn_x   <= r3_sgn_x;
            r4_sgn_y   <= r3_sgn_y;
            r4_px0     <= 65'(r3_ax) * 65'(r3_gm[31:0]);
            r4_px1     <= 65'(r3_ax) * 65'(r3_gm[63:32]);
            r4_px2     <= 65'(r3_ax) * 65'(r3_gm[95:64]);
            r4_py0     <= 65'(r3_ay) * 65'(r3_gm[31:0]);
            r4_py1     <= 65'(r3_ay) * 65'(r3_gm[63:32]);
            r4_py2     <= 65'(r3_ay) * 65'(r3_gm[95:64]);
        end
    end

    // ---------------- P5: numerators, root chain entry ----------------
    t_sq r5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5.valid <= 1'b0;
        end else if (w_en) begin
            r5.valid   <= r4_valid;
            r5.applied <= r4_applied;
            r5.sgn_x   <= r4_sgn_x;
            r5.sgn_y   <= r4_sgn_y;
            r5.num_x   <= NUM_W'(r4_px0) + (NUM_W'(r4_px1) << 32) + (NUM_W'(r4_px2) << 64);
            r5.num_y   <= NUM_W'(r4_py0) + (NUM_W'(r4_py1) << 32) + (NUM_W'(r4_py2) << 64);
            r5.dsq     <= r4_dsq;
            r5.rad     <= r4_dsq;
            r5.rem     <= '0;
            r5.root    <= '0;
        end
    end

    // ---------------- square root: one digit per stage ----------------
    t_sq w_sq [ROOT_W+1];

    assign w_sq[0] = r5;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
        gpf_sqrt_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_stg   (w_sq[k]),
            .o_stg   (w_sq[k+1])
        );
    end

    // ---------------- P6: D*d partials ----------------
    logic             r6_valid;
    logic             r6_applied;
    logic             r6_sgn_x, r6_sgn_y;
    logic [NUM_W-1:0] r6_num_x, r6_num_y;
    logic [64:0]      r6_dp0, r6_dp1;
    logic [34:0]      r6_dp2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else if (w_en) begin
            r6_valid <= w_sq[ROOT_W].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_applied <= w_sq[ROOT_W].applied;
            r6_sgn_x   <= w_sq[ROOT_W].sgn_x;
            r6_sgn_y   <= w_sq[ROOT_W].sgn_y;
            r6_num_x   <= w_sq[ROOT_W].num_x;
            r6_num_y   <= w_sq[ROOT_W].num_y;
            r6_dp0     <= 65'(w_sq[ROOT_W].dsq[31:0])  * 65'(w_sq[ROOT_W].root);
            r6_dp1     <= 65'(w_sq[ROOT_W].dsq[63:32]) * 65'(w_sq[ROOT_W].root);
            r6_dp2     <= 35'(w_sq[ROOT_W].dsq[65:64]) * 35'(w_sq[ROOT_W].root);
        end
    end

    // ---------------- P7: denominator ----------------
    logic             r7_valid;
    logic             r7_applied;
    logic             r7_sgn_x, r7_sgn_y;
    logic [NUM_W-1:0] r7_num_x, r7_num_y;
    logic [DEN_W-1:0] r7_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_valid <= 1'b0;
        end else if (w_en) begin
            r7_valid <= r6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_applied <= r6_applied;
            r7_sgn_x   <= r6_sgn_x;
            r7_sgn_y   <= r6_sgn_y;
            r7_num_x   <= r6_num_x;
            r7_num_y   <= r6_num_y;
            r7_den     <= DEN_W'(r6_dp0) + (DEN_W'(r6_dp1) << 32) + (DEN_W'(r6_dp2) << 64);
        end
    end

    // ---------------- P8: overflow test, divider entry ----------------
    // quotient >= 2^48 exactly when num / 2^48 (floored) reaches den
    t_dv r8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8.valid <= 1'b0;
        end else if (w_en) begin
            r8.valid   <= r7_valid;
            r8.applied <= r7_applied;
            r8.sgn_x   <= r7_sgn_x;
            r8.sgn_y   <= r7_sgn_y;
            r8.big_x   <= (DEN_W'(r7_num_x[NUM_W-1:Q_W]) >= r7_den);
            r8.big_y   <= (DEN_W'(r7_num_y[NUM_W-1:Q_W]) >= r7_den);
            r8.den     <= r7_den;
            r8.rem_x   <= DEN_W'(r7_num_x[NUM_W-1:Q_W]);
            r8.rem_y   <= DEN_W'(r7_num_y[NUM_W-1:Q_W]);
            r8.lo_x    <= r7_num_x[Q_W-1:0];
            r8.lo_y    <= r7_num_y[Q_W-1:0];
            r8.q_x     <= '0;
            r8.q_y     <= '0;
        end
    end

    // ---------------- divider: one quotient bit per stage ----------------
    t_dv w_dv [Q_W+1];

    assign w_dv[0] = r8;

    for (genvar k = 0; k < Q_W; k++) begin : g_div
        gpf_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_stg   (w_dv[k]),
            .o_stg   (w_dv[k+1])
        );
    end

    // ---------------- clamp and sign into the result queue ----------------
    t_dv          w_fin;
    t_res         w_res;
    logic [F_W:0] w_xp, w_xn, w_yp, w_yn;
    logic [F_W:0] w_ax, w_bx, w_ay, w_by;

    assign w_fin = w_dv[Q_W];

    always_comb begin
        w_xp = clamp_pos(w_fin.q_x, w_fin.big_x);
        w_xn = clamp_neg(w_fin.q_x, w_fin.big_x);
        w_yp = clamp_pos(w_fin.q_y, w_fin.big_y);
        w_yn = clamp_neg(w_fin.q_y, w_fin.big_y);
        // force on A points toward B
        w_ax = w_fin.sgn_x ? w_xn : w_xp;
        w_bx = w_fin.sgn_x ? w_xp : w_xn;
        w_ay = w_fin.sgn_y ? w_yn : w_yp;
        w_by = w_fin.sgn_y ? w_yp : w_yn;
        if (w_fin.applied) begin
            w_res.fax       = w_ax[F_W-1:0];
            w_res.fbx       = w_bx[F_W-1:0];
            w_res.fay       = w_ay[F_W-1:0];
            w_res.fby       = w_by[F_W-1:0];
            w_res.applied   = 1'b1;
            w_res.saturated = w_ax[F_W] | w_bx[F_W] | w_ay[F_W] | w_by[F_W];
        end else begin
            w_res = '0;
        end
    end

    t_res w_out;

    gpf_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_en & w_fin.valid),
        .i_data  (w_res),
        .o_full  (w_full),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (w_out)
    );

    assign o_force_a_x = w_out.fax;
    assign o_force_a_y = w_out.fay;
    assign o_force_b_x = w_out.fbx;
    assign o_force_b_y = w_out.fby;
    assign o_applied   = w_out.applied;
    assign o_saturated = w_out.saturated;

endmodule
